[hdl/c2i_pkg.sv]
// ----------------------------------------------------------------------------
// c2i_pkg
// Shared types and constants of the col2im accumulation core: field widths,
// register reset values, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package c2i_pkg;

   // default sizing of the image store and kernel check
   localparam int DEF_MAX_IMAGE_SIDE = 32;
   localparam int DEF_MAX_CHANNELS   = 4;
   localparam int DEF_MAX_KERNEL     = 7;

   // item field widths
   localparam int PATCH_W = 10;
   localparam int ROW_W   = 8;
   localparam int VALUE_W = 16;
   localparam int PIX_W   = 5;
   localparam int PCH_W   = 2;
   localparam int SUM_W   = 22;

   // register widths
   localparam int KSIZE_W  = 3;
   localparam int STRIDE_W = 4;
   localparam int PAD_W    = 3;
   localparam int GEOM_W   = 6;
   localparam int CHCNT_W  = 3;

   // port widths
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 24;

   // signed pixel position width
   localparam int POS_W = 16;

   // register reset values
   localparam logic [KSIZE_W-1:0]  RST_KERNEL_SIZE   = 3'd3;
   localparam logic [STRIDE_W-1:0] RST_STRIDE        = 4'd1;
   localparam logic [PAD_W-1:0]    RST_PADDING       = 3'd0;
   localparam logic [GEOM_W-1:0]   RST_PATCHES_WIDE  = 6'd28;
   localparam logic [GEOM_W-1:0]   RST_PATCHES_HIGH  = 6'd28;
   localparam logic [GEOM_W-1:0]   RST_IMAGE_WIDTH   = 6'd28;
   localparam logic [GEOM_W-1:0]   RST_IMAGE_HEIGHT  = 6'd28;
   localparam logic [CHCNT_W-1:0]  RST_CHANNEL_COUNT = 3'd3;

   // saturation limits of a pixel sum
   localparam logic [SUM_W-1:0] SUM_MAX_BITS = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN_BITS = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_READ = 1'b1
   } c2i_op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_KERNEL_SIZE   = 3'd0,
      REG_STRIDE        = 3'd1,
      REG_PADDING       = 3'd2,
      REG_PATCHES_WIDE  = 3'd3,
      REG_PATCHES_HIGH  = 3'd4,
      REG_IMAGE_WIDTH   = 3'd5,
      REG_IMAGE_HEIGHT  = 3'd6,
      REG_CHANNEL_COUNT = 3'd7
   } c2i_reg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_SPLIT,
      ST_PLACE,
      ST_ADDRESS,
      ST_FETCH,
      ST_UPDATE,
      ST_REPLY
   } c2i_state_type;

   typedef struct packed {
      c2i_op_type                 op;
      logic [PATCH_W-1:0]         patch_index;
      logic [ROW_W-1:0]           row_index;
      logic signed [VALUE_W-1:0]  element_value;
      logic [PIX_W-1:0]           pixel_x;
      logic [PIX_W-1:0]           pixel_y;
      logic [PCH_W-1:0]           pixel_channel;
   } c2i_item_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic start_split;
      logic calc_pos;
      logic calc_addr;
      logic mem_read;
      logic mem_write_sum;
      logic mem_write_zero;
      logic out_load;
      logic clear_step;
   } c2i_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_read;
      logic div_done;
      logic split_done;
      logic hit;
      logic clear_last;
      logic out_full;
   } c2i_stat_type;

endpackage

[hdl/col2im_accumulate_core.sv]
// ----------------------------------------------------------------------------
// col2im_accumulate_core
// col2im scatter-accumulation of one sample into a cleared image store.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries items. tuser selects the operation: 0 adds a Q8.8 patch
//   element at (patch_index, row_index), 1 reads and clears one pixel.
//   rsp_* returns one transaction per read: the 22-bit pixel sum and an
//   outside flag for coordinates beyond the configured image. Adds return
//   nothing. csr_* writes the geometry registers; csr_ready is always high,
//   and writes belong only to times when no item is in flight.
// Sequence:
//   An add occupies the core through two radix-4 divider passes (patch by
//   patch width alongside row by kernel area, then offset by kernel side),
//   placement, address and a read-modify-write of the store. A read passes
//   through address and fetch into the result register.
// Reset:
//   The store, MAX_CHANNELS times MAX_IMAGE_SIDE squared entries (4096 by
//   default), is swept to zero one entry per cycle with req_tready low.
// Stall:
//   A finished read waits in the result register; further adds proceed,
//   and the next read holds until rsp_tready frees that register.
// ----------------------------------------------------------------------------
module col2im_accumulate_core #(
   parameter int MAX_IMAGE_SIDE = c2i_pkg::DEF_MAX_IMAGE_SIDE,
   parameter int MAX_CHANNELS   = c2i_pkg::DEF_MAX_CHANNELS,
   parameter int MAX_KERNEL     = c2i_pkg::DEF_MAX_KERNEL
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [c2i_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [c2i_pkg::CSR_DATA_W-1:0]     csr_data,
   // item channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // patch_index[9:0], row_index[17:10], element_value[33:18],
   // pixel_x[38:34], pixel_y[43:39], pixel_channel[45:44], zero[47:46]
   input  logic [c2i_pkg::REQ_DATA_W-1:0]     req_tdata,
   // op[0]
   input  logic                               req_tuser,
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // pixel_sum[21:0], zero[23:22]
   output logic [c2i_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // outside_image[0]
   output logic                               rsp_tuser
);

   import c2i_pkg::*;

   c2i_cmd_type  cmd;
   c2i_stat_type stat;
   c2i_item_type req_item;
   logic [SUM_W-1:0] pixel_sum;

   // unpack the item transaction
   always_comb begin
      req_item.op            = c2i_op_type'(req_tuser);
      req_item.patch_index   = req_tdata[9:0];
      req_item.row_index     = req_tdata[17:10];
      req_item.element_value = $signed(req_tdata[33:18]);
      req_item.pixel_x       = req_tdata[38:34];
      req_item.pixel_y       = req_tdata[43:39];
      req_item.pixel_channel = req_tdata[45:44];
   end

   assign csr_ready = 1'b1;

   c2i_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_op   (req_tuser),
      .req_ready(req_tready),
      .stat     (stat),
      .cmd      (cmd)
   );

   c2i_datapath #(
      .MAX_IMAGE_SIDE(MAX_IMAGE_SIDE),
      .MAX_CHANNELS  (MAX_CHANNELS),
      .MAX_KERNEL    (MAX_KERNEL)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .csr_write    (csr_valid & csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_item     (req_item),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_pixel_sum(pixel_sum),
      .rsp_outside  (rsp_tuser)
   );

   // pack the result transaction
   assign rsp_tdata = {(RSP_DATA_W - SUM_W)'(0), pixel_sum};

endmodule

[hdl/c2i_divider.sv]
// ----------------------------------------------------------------------------
// c2i_divider
// Unsigned restoring divider, two quotient bits per clock. A start pulse
// loads the operands; done rises once quotient and remainder are final and
// holds until the next start.
// ----------------------------------------------------------------------------
module c2i_divider #(
   parameter int NUM_W = 8,
   parameter int DEN_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0] denominator,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder,
   output logic             done
);

   localparam int STEPS  = 2;
   localparam int CYCLES = (NUM_W + STEPS - 1) / STEPS;
   localparam int WORK_W = CYCLES * STEPS;
   localparam int CNT_W  = $clog2(CYCLES + 1);

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [WORK_W-1:0] work_ff, work_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   // shift numerator bits into the partial remainder, subtract where it fits
   always_comb begin
      logic [DEN_W:0]    trial;
      logic [DEN_W-1:0]  rem_v;
      logic [WORK_W-1:0] work_v;
      trial    = '0;
      rem_v    = rem_ff;
      work_v   = work_ff;
      rem_in   = rem_ff;
      work_in  = work_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      for (int i = 0; i < STEPS; i++) begin
         trial  = {rem_v, work_v[WORK_W-1]};
         work_v = {work_v[WORK_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_v     = DEN_W'(trial - {1'b0, den_ff});
            work_v[0] = 1'b1;
         end else begin
            rem_v = trial[DEN_W-1:0];
         end
      end
      if (start) begin
         rem_in   = '0;
         work_in  = WORK_W'(numerator);
         den_in   = denominator;
         count_in = '0;
         busy_in  = 1'b1;
         done_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in   = rem_v;
         work_in  = work_v;
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   // operands and partial results hold no reset
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      work_ff <= work_in;
      den_ff  <= den_in;
   end

   assign quotient  = work_ff[NUM_W-1:0];
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

[hdl/c2i_datapath.sv]
// ----------------------------------------------------------------------------
// c2i_datapath
// Configuration registers, the two dividers that split patch and row
// indexes, pixel placement, the accumulator store with its read-modify-write
// and clearing sweep, and the result register.
// ----------------------------------------------------------------------------
module c2i_datapath #(
   parameter int MAX_IMAGE_SIDE = c2i_pkg::DEF_MAX_IMAGE_SIDE,
   parameter int MAX_CHANNELS   = c2i_pkg::DEF_MAX_CHANNELS,
   parameter int MAX_KERNEL     = c2i_pkg::DEF_MAX_KERNEL
) (
   input  logic                                clock,
   input  logic                                reset,
   input  c2i_pkg::c2i_cmd_type                cmd,
   output c2i_pkg::c2i_stat_type               stat,
   input  logic                                csr_write,
   input  logic [c2i_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [c2i_pkg::CSR_DATA_W-1:0]      csr_data,
   input  c2i_pkg::c2i_item_type               req_item,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [c2i_pkg::SUM_W-1:0]           rsp_pixel_sum,
   output logic                                rsp_outside
);

   import c2i_pkg::*;

   localparam int PLANE  = MAX_IMAGE_SIDE * MAX_IMAGE_SIDE;
   localparam int DEPTH  = MAX_CHANNELS * PLANE;
   localparam int ADDR_W = $clog2(DEPTH);

   // configuration registers
   logic [KSIZE_W-1:0]  k_ff, k_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic [PAD_W-1:0]    pad_ff, pad_in;
   logic [GEOM_W-1:0]   pw_ff, pw_in;
   logic [GEOM_W-1:0]   ph_ff, ph_in;
   logic [GEOM_W-1:0]   iw_ff, iw_in;
   logic [GEOM_W-1:0]   ih_ff, ih_in;
   logic [CHCNT_W-1:0]  cc_ff, cc_in;

   // item and intermediate results
   c2i_item_type             item_ff, item_in;
   logic [ROW_W-1:0]         ch_ff, ch_in;
   logic signed [POS_W-1:0]  py_ff, py_in;
   logic signed [POS_W-1:0]  px_ff, px_in;
   logic                     hit_ff, hit_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic [SUM_W-1:0]         mem_q_ff;
   logic [ADDR_W-1:0]        clear_cnt_ff, clear_cnt_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]         rsp_sum_ff, rsp_sum_in;
   logic                     rsp_outside_ff, rsp_outside_in;

   // divider connections
   logic [PATCH_W-1:0] quo_a;
   logic [GEOM_W-1:0]  rem_a;
   logic               done_a;
   logic               start_b;
   logic [ROW_W-1:0]   num_b;
   logic [GEOM_W-1:0]  den_b;
   logic [ROW_W-1:0]   quo_b;
   logic [GEOM_W-1:0]  rem_b;
   logic               done_b;

   // derived geometry
   logic [GEOM_W-1:0]  k_ext;
   logic [GEOM_W-1:0]  area;
   logic [GEOM_W-1:0]  w_lim;
   logic [GEOM_W-1:0]  h_lim;
   logic [CHCNT_W-1:0] ch_lim;
   logic               geom_ok;

   // store access
   logic [SUM_W-1:0]   store [DEPTH];
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [SUM_W-1:0]   mem_wdata;
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   sum_sat;

   // take register writes
   always_comb begin
      k_in      = k_ff;
      stride_in = stride_ff;
      pad_in    = pad_ff;
      pw_in     = pw_ff;
      ph_in     = ph_ff;
      iw_in     = iw_ff;
      ih_in     = ih_ff;
      cc_in     = cc_ff;
      if (csr_write) begin
         case (c2i_reg_type'(csr_index))
            REG_KERNEL_SIZE:   k_in      = csr_data[KSIZE_W-1:0];
            REG_STRIDE:        stride_in = csr_data[STRIDE_W-1:0];
            REG_PADDING:       pad_in    = csr_data[PAD_W-1:0];
            REG_PATCHES_WIDE:  pw_in     = csr_data[GEOM_W-1:0];
            REG_PATCHES_HIGH:  ph_in     = csr_data[GEOM_W-1:0];
            REG_IMAGE_WIDTH:   iw_in     = csr_data[GEOM_W-1:0];
            REG_IMAGE_HEIGHT:  ih_in     = csr_data[GEOM_W-1:0];
            REG_CHANNEL_COUNT: cc_in     = csr_data[CHCNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff      <= RST_KERNEL_SIZE;
         stride_ff <= RST_STRIDE;
         pad_ff    <= RST_PADDING;
         pw_ff     <= RST_PATCHES_WIDE;
         ph_ff     <= RST_PATCHES_HIGH;
         iw_ff     <= RST_IMAGE_WIDTH;
         ih_ff     <= RST_IMAGE_HEIGHT;
         cc_ff     <= RST_CHANNEL_COUNT;
      end else begin
         k_ff      <= k_in;
         stride_ff <= stride_in;
         pad_ff    <= pad_in;
         pw_ff     <= pw_in;
         ph_ff     <= ph_in;
         iw_ff     <= iw_in;
         ih_ff     <= ih_in;
         cc_ff     <= cc_in;
      end
   end

   // clamp image and channel limits, check kernel and patch geometry
   always_comb begin
      k_ext   = GEOM_W'(k_ff);
      area    = GEOM_W'(k_ext * k_ext);
      w_lim   = (int'(iw_ff) > MAX_IMAGE_SIDE) ? GEOM_W'(MAX_IMAGE_SIDE) : iw_ff;
      h_lim   = (int'(ih_ff) > MAX_IMAGE_SIDE) ? GEOM_W'(MAX_IMAGE_SIDE) : ih_ff;
      ch_lim  = (int'(cc_ff) > MAX_CHANNELS) ? CHCNT_W'(MAX_CHANNELS) : cc_ff;
      geom_ok = (k_ff != '0) && (int'(k_ff) <= MAX_KERNEL) && (pw_ff != '0);
   end

   // patch number into patch row and column
   c2i_divider #(
      .NUM_W(PATCH_W),
      .DEN_W(GEOM_W)
   ) u_div_patch (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.load),
      .numerator  (req_item.patch_index),
      .denominator(pw_ff),
      .quotient   (quo_a),
      .remainder  (rem_a),
      .done       (done_a)
   );

   // first pass: row by kernel area; second pass: offset by kernel side
   assign start_b = cmd.load | cmd.start_split;
   assign num_b   = cmd.start_split ? ROW_W'(rem_b) : req_item.row_index;
   assign den_b   = cmd.start_split ? k_ext : area;

   c2i_divider #(
      .NUM_W(ROW_W),
      .DEN_W(GEOM_W)
   ) u_div_row (
      .clock      (clock),
      .reset      (reset),
      .start      (start_b),
      .numerator  (num_b),
      .denominator(den_b),
      .quotient   (quo_b),
      .remainder  (rem_b),
      .done       (done_b)
   );

   // capture item, channel, pixel position, address
   always_comb begin
      logic [PATCH_W+STRIDE_W-1:0] prod_y;
      logic [GEOM_W+STRIDE_W-1:0]  prod_x;
      logic [ROW_W-1:0]            ch_sel;
      logic [POS_W-1:0]            y_sel;
      logic [POS_W-1:0]            x_sel;
      logic                        hit_add;
      logic                        hit_read;
      logic [ADDR_W-1:0]           addr_calc;
      item_in = item_ff;
      ch_in   = ch_ff;
      py_in   = py_ff;
      px_in   = px_ff;
      hit_in  = hit_ff;
      addr_in = addr_ff;

      prod_y = (PATCH_W+STRIDE_W)'(quo_a) * (PATCH_W+STRIDE_W)'(stride_ff);
      prod_x = (GEOM_W+STRIDE_W)'(rem_a) * (GEOM_W+STRIDE_W)'(stride_ff);

      hit_add = geom_ok
         && (ch_ff < ROW_W'(ch_lim))
         && (quo_a < PATCH_W'(ph_ff))
         && !py_ff[POS_W-1] && !px_ff[POS_W-1]
         && (unsigned'(py_ff) < POS_W'(h_lim))
         && (unsigned'(px_ff) < POS_W'(w_lim));
      hit_read = (GEOM_W'(item_ff.pixel_x) < w_lim)
         && (GEOM_W'(item_ff.pixel_y) < h_lim)
         && (CHCNT_W'(item_ff.pixel_channel) < ch_lim);

      if (item_ff.op == OP_READ) begin
         ch_sel = ROW_W'(item_ff.pixel_channel);
         y_sel  = POS_W'(item_ff.pixel_y);
         x_sel  = POS_W'(item_ff.pixel_x);
      end else begin
         ch_sel = ch_ff;
         y_sel  = unsigned'(py_ff);
         x_sel  = unsigned'(px_ff);
      end
      addr_calc = ADDR_W'(ch_sel) * ADDR_W'(PLANE)
                + ADDR_W'(y_sel) * ADDR_W'(MAX_IMAGE_SIDE)
                + ADDR_W'(x_sel);

      if (cmd.load) begin
         item_in = req_item;
      end
      if (cmd.start_split) begin
         ch_in = quo_b;
      end
      if (cmd.calc_pos) begin
         py_in = $signed(POS_W'(prod_y)) + $signed(POS_W'(quo_b))
               - $signed(POS_W'(pad_ff));
         px_in = $signed(POS_W'(prod_x)) + $signed(POS_W'(rem_b))
               - $signed(POS_W'(pad_ff));
      end
      if (cmd.calc_addr) begin
         hit_in  = (item_ff.op == OP_READ) ? hit_read : hit_add;
         addr_in = hit_in ? addr_calc : '0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      ch_ff   <= ch_in;
      py_ff   <= py_in;
      px_ff   <= px_in;
      hit_ff  <= hit_in;
      addr_ff <= addr_in;
   end

   // add the element to the stored sum, saturate at the sum limits
   always_comb begin
      sum_wide = {mem_q_ff[SUM_W-1], mem_q_ff}
               + {{(SUM_W+1-VALUE_W){item_ff.element_value[VALUE_W-1]}},
                  item_ff.element_value};
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? SUM_MIN_BITS : SUM_MAX_BITS;
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   // one write port shared by the clearing sweep, accumulate and read-clear
   always_comb begin
      mem_we       = cmd.clear_step | cmd.mem_write_sum | cmd.mem_write_zero;
      mem_waddr    = cmd.clear_step ? clear_cnt_ff : addr_ff;
      mem_wdata    = cmd.mem_write_sum ? sum_sat : '0;
      clear_cnt_in = cmd.clear_step ? clear_cnt_ff + 1'b1 : clear_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_waddr] <= mem_wdata;
      end
      if (cmd.mem_read) begin
         mem_q_ff <= store[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else begin
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // result register: load on reply, drop when the transaction completes
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_sum_in     = rsp_sum_ff;
      rsp_outside_in = rsp_outside_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_sum_in     = hit_ff ? mem_q_ff : '0;
         rsp_outside_in = !hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sum_ff     <= rsp_sum_in;
      rsp_outside_ff <= rsp_outside_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_sum = rsp_sum_ff;
   assign rsp_outside   = rsp_outside_ff;

   // status back to the controller
   always_comb begin
      stat.op_read    = (item_ff.op == OP_READ);
      stat.div_done   = done_a & done_b;
      stat.split_done = done_b;
      stat.hit        = hit_ff;
      stat.clear_last = (clear_cnt_ff == ADDR_W'(DEPTH - 1));
      stat.out_full   = rsp_valid_ff;
   end

endmodule

[hdl/c2i_ctrl.sv]
// ----------------------------------------------------------------------------
// c2i_ctrl
// Sequencer of the col2im accumulation core: clearing sweep after reset,
// item acceptance, divider phases, placement, store read-modify-write and
// the reply hand-off to the result register.
// ----------------------------------------------------------------------------
module c2i_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_op,
   output logic                   req_ready,
   input  c2i_pkg::c2i_stat_type  stat,
   output c2i_pkg::c2i_cmd_type   cmd
);

   import c2i_pkg::*;

   c2i_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (c2i_op_type'(req_op) == OP_READ) ? ST_ADDRESS : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (stat.div_done) state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            if (stat.split_done) state_in = ST_PLACE;
         end
         ST_PLACE:   state_in = ST_ADDRESS;
         ST_ADDRESS: state_in = ST_FETCH;
         ST_FETCH:   state_in = stat.op_read ? ST_REPLY : ST_UPDATE;
         ST_UPDATE:  state_in = ST_IDLE;
         ST_REPLY: begin
            if (!stat.out_full) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIVIDE:  cmd.start_split = stat.div_done;
         ST_SPLIT:   ;
         ST_PLACE:   cmd.calc_pos  = 1'b1;
         ST_ADDRESS: cmd.calc_addr = 1'b1;
         ST_FETCH:   cmd.mem_read  = 1'b1;
         ST_UPDATE:  cmd.mem_write_sum = stat.hit;
         ST_REPLY: begin
            cmd.out_load       = !stat.out_full;
            cmd.mem_write_zero = !stat.out_full & stat.hit;
         end
         default: ;
      endcase
   end

endmodule

[test/col2im_accumulate_core_tb.sv]
// ----------------------------------------------------------------------------
// col2im_accumulate_core_tb
// Self-checking testbench of the col2im accumulation core.
// A scoreboard keeps its own image store and geometry registers, predicts
// the sum and outside flag of every read, and compares each returned
// transaction in order. The core is checked first with a short directed
// sequence, then with random phases. Each phase reprograms the geometry,
// including extreme and degenerate settings. Both channels idle at random,
// and the result side stalls once for a long stretch.
// ----------------------------------------------------------------------------
module col2im_accumulate_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import c2i_pkg::*;

   localparam int SIDE            = DEF_MAX_IMAGE_SIDE;
   localparam int STORE_DEPTH     = DEF_MAX_CHANNELS * SIDE * SIDE;
   localparam int SUM_MAX_INT     = 2097151;
   localparam int SUM_MIN_INT     = -2097152;
   localparam int ITEM_LATENCY    = 32;
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int PRESSURE_CYCLES = 400;
   localparam int NUM_PLANNED     = 11;
   localparam int NUM_RANDOM      = 2;
   localparam int MAX_PRINTED     = 40;

   typedef struct {
      logic signed [SUM_W-1:0] pixel_sum;
      logic                    outside_image;
   } pixel_result_type;

   // --------------------------------------------------------------------------
   // scoreboard: image store prediction and in-order result checking
   // --------------------------------------------------------------------------
   class col2im_scoreboard;
      logic [KSIZE_W-1:0]      kernel_size;
      logic [STRIDE_W-1:0]     stride;
      logic [PAD_W-1:0]        padding;
      logic [GEOM_W-1:0]       patches_wide;
      logic [GEOM_W-1:0]       patches_high;
      logic [GEOM_W-1:0]       image_width;
      logic [GEOM_W-1:0]       image_height;
      logic [CHCNT_W-1:0]      channel_count;
      logic signed [SUM_W-1:0] pixel_sums [STORE_DEPTH];
      pixel_result_type        pending_reads [$];
      int                      errors;
      int                      items_noted;
      int                      reads_noted;
      int                      results_checked;
      int                      saturations;

      function new();
         kernel_size   = RST_KERNEL_SIZE;
         stride        = RST_STRIDE;
         padding       = RST_PADDING;
         patches_wide  = RST_PATCHES_WIDE;
         patches_high  = RST_PATCHES_HIGH;
         image_width   = RST_IMAGE_WIDTH;
         image_height  = RST_IMAGE_HEIGHT;
         channel_count = RST_CHANNEL_COUNT;
         foreach (pixel_sums[i]) pixel_sums[i] = '0;
         errors          = 0;
         items_noted     = 0;
         reads_noted     = 0;
         results_checked = 0;
         saturations     = 0;
      endfunction

      function int clamp(int value, int limit);
         return (value > limit) ? limit : value;
      endfunction

      function int width_limit();
         return clamp(image_width, SIDE);
      endfunction

      function int height_limit();
         return clamp(image_height, SIDE);
      endfunction

      function int chan_limit();
         return clamp(channel_count, DEF_MAX_CHANNELS);
      endfunction

      function void write_register(c2i_reg_type index, logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_KERNEL_SIZE:   kernel_size   = value[KSIZE_W-1:0];
            REG_STRIDE:        stride        = value[STRIDE_W-1:0];
            REG_PADDING:       padding       = value[PAD_W-1:0];
            REG_PATCHES_WIDE:  patches_wide  = value[GEOM_W-1:0];
            REG_PATCHES_HIGH:  patches_high  = value[GEOM_W-1:0];
            REG_IMAGE_WIDTH:   image_width   = value[GEOM_W-1:0];
            REG_IMAGE_HEIGHT:  image_height  = value[GEOM_W-1:0];
            REG_CHANNEL_COUNT: channel_count = value[CHCNT_W-1:0];
            default: ;
         endcase
      endfunction

      // find the store entry an add lands on; 0 when it lands nowhere
      function bit locate(c2i_item_type item, output int slot);
         int k, area, chan, off, prow, pcol, px, py;
         slot = 0;
         k = kernel_size;
         if (k == 0 || k > DEF_MAX_KERNEL || patches_wide == 0) return 0;
         area = k * k;
         chan = int'(item.row_index) / area;
         off  = int'(item.row_index) % area;
         prow = int'(item.patch_index) / int'(patches_wide);
         pcol = int'(item.patch_index) % int'(patches_wide);
         if (chan >= chan_limit() || prow >= int'(patches_high)) return 0;
         py = prow * int'(stride) - int'(padding) + off / k;
         px = pcol * int'(stride) - int'(padding) + off % k;
         if (px < 0 || py < 0 || px >= width_limit() || py >= height_limit()) return 0;
         slot = (chan * SIDE + py) * SIDE + px;
         return 1;
      endfunction

      // apply one accepted item; a read queues its expected result
      function void note_item(c2i_item_type item);
         int               slot, total;
         pixel_result_type due;
         items_noted++;
         if (item.op == OP_ADD) begin
            if (locate(item, slot)) begin
               total = int'(pixel_sums[slot]) + int'($signed(item.element_value));
               if (total > SUM_MAX_INT) begin
                  total = SUM_MAX_INT;
                  saturations++;
               end else if (total < SUM_MIN_INT) begin
                  total = SUM_MIN_INT;
                  saturations++;
               end
               pixel_sums[slot] = total[SUM_W-1:0];
            end
         end else begin
            reads_noted++;
            if (int'(item.pixel_x) >= width_limit() || int'(item.pixel_y) >= height_limit() ||
                int'(item.pixel_channel) >= chan_limit()) begin
               due.pixel_sum     = '0;
               due.outside_image = 1'b1;
            end else begin
               slot = (int'(item.pixel_channel) * SIDE + int'(item.pixel_y)) * SIDE +
                      int'(item.pixel_x);
               due.pixel_sum     = pixel_sums[slot];
               due.outside_image = 1'b0;
               pixel_sums[slot]  = '0;
            end
            pending_reads.push_back(due);
         end
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, msg);
      endtask

      // compare one returned transaction with the oldest queued read
      task check_result(logic [RSP_DATA_W-1:0] data, logic outside);
         pixel_result_type        due;
         logic signed [SUM_W-1:0] got_sum;
         got_sum = data[SUM_W-1:0];
         if (pending_reads.size() == 0) begin
            report_mismatch($sformatf("result with no read waiting: sum %0d outside %0b",
                                      got_sum, outside));
            return;
         end
         due = pending_reads.pop_front();
         results_checked++;
         if (got_sum !== due.pixel_sum)
            report_mismatch($sformatf("result %0d: pixel_sum %0d, expected %0d",
                                      results_checked, got_sum, due.pixel_sum));
         if (outside !== due.outside_image)
            report_mismatch($sformatf("result %0d: outside_image %0b, expected %0b",
                                      results_checked, outside, due.outside_image));
      endtask
   endclass

   // --------------------------------------------------------------------------
   // signals and block under test
   // --------------------------------------------------------------------------
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;

   col2im_accumulate_core DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   col2im_scoreboard sb = new();

   // register settings per phase: the eight registers in index order, then item count
   int plan [NUM_PLANNED][9] = '{
      '{1, 1,  0,  4,  4,  4,  4, 1, 120},  // smallest kernel
      '{7, 8,  6, 32, 32, 32, 32, 4, 140},  // largest kernel, image and channel count
      '{3, 2,  1,  5,  5, 10, 10, 2, 130},
      '{2, 1,  0,  3,  3,  4,  4, 4, 120},
      '{0, 1,  0,  4,  4,  4,  4, 2,  50},  // kernel of zero
      '{7, 1,  1,  0,  4,  4,  4, 2,  50},  // zero patches per row
      '{3, 0,  2,  4,  4,  6,  6, 2, 100},  // zero stride
      '{5, 3,  7, 63, 63, 63, 63, 7, 130},  // oversize image and channels
      '{4, 15, 0,  2,  2, 31, 31, 3, 100},
      '{7, 1,  6,  1,  1,  1,  1, 1, 100},  // one-pixel image under a wide kernel
      '{3, 1,  0,  4,  0,  0,  0, 0,  40}   // empty image, no patch rows
   };

   bit sender_steady = 1'b0;
   bit have_last     = 1'b0;
   int last_slot     = 0;
   int phases_run    = 0;

   // --------------------------------------------------------------------------
   // clock
   // --------------------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // --------------------------------------------------------------------------
   // item generation
   // --------------------------------------------------------------------------
   function automatic c2i_item_type random_item();
      c2i_item_type item;
      item.op            = c2i_op_type'($urandom_range(0, 1));
      item.patch_index   = $urandom_range(0, 1023);
      item.row_index     = $urandom_range(0, 255);
      item.element_value = $urandom_range(0, 65535);
      item.pixel_x       = $urandom_range(0, 31);
      item.pixel_y       = $urandom_range(0, 31);
      item.pixel_channel = $urandom_range(0, 3);
      return item;
   endfunction

   function automatic c2i_item_type make_add(int patch, int row, int value);
      c2i_item_type item;
      item               = random_item();
      item.op            = OP_ADD;
      item.patch_index   = patch;
      item.row_index     = row;
      item.element_value = value;
      return item;
   endfunction

   function automatic c2i_item_type make_read(int x, int y, int chan);
      c2i_item_type item;
      item               = random_item();
      item.op            = OP_READ;
      item.pixel_x       = x;
      item.pixel_y       = y;
      item.pixel_channel = chan;
      return item;
   endfunction

   function automatic c2i_item_type read_at(int slot);
      return make_read(slot % SIDE, (slot / SIDE) % SIDE, slot / (SIDE * SIDE));
   endfunction

   // add aimed at a patch and row that exist under the current geometry
   function automatic c2i_item_type shaped_add();
      c2i_item_type item;
      int           patches, rows, roll;
      item    = random_item();
      item.op = OP_ADD;
      patches = int'(sb.patches_wide) * int'(sb.patches_high);
      rows    = sb.chan_limit() * int'(sb.kernel_size) * int'(sb.kernel_size);
      if (patches > 0) item.patch_index = $urandom_range(0, sb.clamp(patches, 1024) - 1);
      if (rows > 0) item.row_index = $urandom_range(0, sb.clamp(rows, 256) - 1);
      roll = $urandom_range(0, 15);
      if (roll == 0) item.element_value = 16'sh7fff;
      else if (roll == 1) item.element_value = 16'sh8000;
      return item;
   endfunction

   // read inside the image, often of the pixel most recently added to
   function automatic c2i_item_type shaped_read();
      if (have_last && $urandom_range(0, 1) == 1) return read_at(last_slot);
      return make_read($urandom_range(0, sb.clamp(sb.width_limit() - 1, 31)),
                       $urandom_range(0, sb.clamp(sb.height_limit() - 1, 31)),
                       $urandom_range(0, sb.clamp(sb.chan_limit() - 1, 3)));
   endfunction

   // --------------------------------------------------------------------------
   // drivers
   // --------------------------------------------------------------------------
   task automatic send_item(c2i_item_type item);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= item.op;
      req_tdata  <= {2'b00, item.pixel_channel, item.pixel_y, item.pixel_x,
                     item.element_value, item.row_index, item.patch_index};
      do @(posedge clock); while (!req_tready);
      sb.note_item(item);
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_register(c2i_reg_type index, int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      sb.write_register(index, value[CSR_DATA_W-1:0]);
   endtask

   // write all eight registers of one setting, then release the channel
   task automatic program_geometry(int values [8]);
      c2i_reg_type index;
      index = index.first();
      do begin
         write_register(index, values[int'(index)]);
         index = index.next();
      end while (index != index.first());
      @(negedge clock);
      csr_valid <= 1'b0;
      have_last = 1'b0;
      phases_run++;
   endtask

   // drop valid, wait for every queued read, then let a trailing add finish
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_reads.size() != 0) @(posedge clock);
      repeat (ITEM_LATENCY) @(posedge clock);
   endtask

   task automatic run_directed();
      // repeated add to one pixel, then read and read again once cleared
      send_item(make_add(0, 0, 32767));
      send_item(make_add(0, 0, 32767));
      send_item(make_read(0, 0, 0));
      send_item(make_read(0, 0, 0));
      // last kernel offset and a neighboring patch column
      send_item(make_add(0, 8, -32768));
      send_item(make_add(1, 0, -1));
      send_item(make_read(2, 2, 0));
      send_item(make_read(1, 0, 0));
      // patch row beyond the grid, channel beyond the count, pixel past the edge
      send_item(make_add(1023, 195, -32768));
      send_item(make_add(0, 255, 1));
      send_item(make_add(783, 26, 100));
      // last patch, last channel in use
      send_item(make_add(783, 18, 7));
      send_item(make_read(27, 27, 2));
      // reads beyond the image or the channel count
      send_item(make_read(31, 31, 3));
      send_item(make_read(28, 0, 0));
      send_item(make_read(0, 28, 0));
      send_item(make_read(0, 0, 3));
      // zero and small values in the second channel
      send_item(make_add(29, 9, 0));
      send_item(make_add(29, 9, 1));
      send_item(make_read(1, 1, 1));
   endtask

   task automatic run_phase(int count);
      c2i_item_type item;
      int           sent, roll, slot, burst;
      sender_steady = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 12) item = random_item();
         else if (roll < 70) item = shaped_add();
         else item = shaped_read();
         if (item.op == OP_ADD && sb.locate(item, slot)) begin
            last_slot = slot;
            have_last = 1'b1;
            // hammer one pixel with an extreme value until it saturates
            if ($urandom_range(0, 79) == 0) begin
               item.element_value = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
               burst = $urandom_range(66, 72);
               repeat (burst) send_item(item);
               item = read_at(slot);
               sent += burst;
            end
         end
         send_item(item);
         sent++;
      end
   endtask

   // --------------------------------------------------------------------------
   // result side: random stalls, calm stretches and one long hold-off
   // --------------------------------------------------------------------------
   initial begin
      int stall_left, window;
      bit calm, pressure_done;
      stall_left    = 0;
      window        = 0;
      calm          = 1'b0;
      pressure_done = 1'b0;
      forever begin
         @(negedge clock);
         if (window == 0) begin
            calm   = ($urandom_range(0, 2) == 0);
            window = $urandom_range(100, 400);
         end
         window--;
         if (!pressure_done && sb.results_checked >= 20) begin
            pressure_done = 1'b1;
            stall_left    = PRESSURE_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap();
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // check every accepted result transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // --------------------------------------------------------------------------
   // watchdog: end the run when no transaction moves for too long
   // --------------------------------------------------------------------------
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // --------------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------------
   initial begin
      int values [8];
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      // planned settings, extremes and degenerate geometry among them
      for (int p = 0; p < NUM_PLANNED; p++) begin
         settle();
         for (int r = 0; r < 8; r++) values[r] = plan[p][r];
         program_geometry(values);
         run_phase(plan[p][8]);
      end

      // random legal settings, kept small so reads often hit
      for (int p = 0; p < NUM_RANDOM; p++) begin
         settle();
         values = '{$urandom_range(1, 7), $urandom_range(1, 8), $urandom_range(0, 6),
                    $urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 16),
                    $urandom_range(1, 16), $urandom_range(1, 4)};
         program_geometry(values);
         run_phase(120);
      end
      settle();

      $display("Sent %0d items (%0d reads) over %0d register settings; %0d results checked",
               sb.items_noted, sb.reads_noted, phases_run + 1, sb.results_checked);
      $display("Sums saturated %0d times; %0d mismatches", sb.saturations, sb.errors);
      if (sb.errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[col2im_accumulate_core.f]
hdl/c2i_pkg.sv
hdl/c2i_divider.sv
hdl/c2i_datapath.sv
hdl/c2i_ctrl.sv
hdl/col2im_accumulate_core.sv
test/col2im_accumulate_core_tb.sv
